[rtl/core/nsr_pkg.sv]
package nsr_pkg;

  localparam int ROOT_W   = 32;
  localparam int STATUS_W = 2;
  localparam int TOL_W    = 8;
  localparam int ITER_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [TOL_W-1:0]  TOL_RESET  = 8'd1;
  localparam logic [ITER_W-1:0] ITER_RESET = 6'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK  = 2'd0,
    STATUS_NEG = 2'd1,
    STATUS_CAP = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    sq_start;
    logic    sq_step;
    logic    seed;
    logic    div_load;
    logic    div_step;
    logic    upd;
    logic    adv;
    logic    out_load;
    status_t fin_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic neg;
    logic zero;
    logic cnt_last;
    logic conv;
    logic capped;
  } sts_t;

endpackage

[rtl/core/nsr_dp.sv]
module nsr_dp #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nsr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] radicand,
  input  nsr_pkg::cmd_t                       cmd,
  output nsr_pkg::sts_t                       sts,
  output logic [nsr_pkg::ROOT_W-1:0]          root,
  output nsr_pkg::status_t                    status
);

  localparam int IN_W     = INT_BITS + FRAC_BITS;
  localparam int QW       = IN_W + FRAC_BITS;
  localparam int SQ_PAIRS = (INT_BITS + 1) / 2;
  localparam int SQ_W     = 2 * SQ_PAIRS;
  localparam int SQ_RW    = SQ_PAIRS + 3;
  localparam int CNT_W    = $clog2(QW + 1);
  localparam int RW       = nsr_pkg::ROOT_W;
  localparam int IW       = nsr_pkg::ITER_W;

  logic [IN_W-1:0]            s;
  logic [SQ_W-1:0]            sq_op;
  logic [SQ_PAIRS:0]          sq_rem;
  logic [SQ_PAIRS-1:0]        sq_root;
  logic [QW-1:0]              x;
  logic [QW-1:0]              xn;
  logic [QW-1:0]              quo;
  logic [QW-1:0]              rem;
  logic [CNT_W-1:0]           cnt;
  logic [IW-1:0]              n;
  logic [nsr_pkg::TOL_W-1:0]  tol;
  logic [IW-1:0]              max_iter;
  logic [RW-1:0]              out_root;
  nsr_pkg::status_t           out_status;

  logic [SQ_RW-1:0]  sq_rem_sh;
  logic [SQ_RW-1:0]  sq_trial;
  logic [SQ_RW-1:0]  sq_diff;
  logic              sq_ge;
  logic [QW:0]       div_sh;
  logic [QW:0]       div_diff;
  logic              div_ge;
  logic [QW-1:0]     xn_calc;
  logic [QW-1:0]     tol_ext;
  logic [QW-1:0]     seed_x;
  logic [IW-1:0]     cap;
  logic [QW+RW-1:0]  xn_wide;
  logic [RW-1:0]     root_sat;

  // One root digit per cycle of the integer floor square root.
  assign sq_rem_sh = {sq_rem, sq_op[SQ_W-1 -: 2]};
  assign sq_trial  = {1'b0, sq_root, 2'b01};
  assign sq_ge     = sq_rem_sh >= sq_trial;
  assign sq_diff   = sq_rem_sh - sq_trial;

  // Restoring division, one quotient bit per cycle.
  assign div_sh   = {rem, quo[QW-1]};
  assign div_ge   = div_sh >= {1'b0, x};
  assign div_diff = div_sh - {1'b0, x};

  assign xn_calc = (quo >> 1) + (x >> 1) + QW'(quo[0] & x[0]);
  assign tol_ext = QW'(tol);
  assign seed_x  = (sq_root == '0) ? (QW'(1) << FRAC_BITS)
                                   : (QW'(sq_root) << FRAC_BITS);
  assign cap     = (max_iter == '0) ? IW'(1) : max_iter;

  assign xn_wide  = {{RW{1'b0}}, xn};
  assign root_sat = (|xn_wide[QW+RW-1:RW]) ? {RW{1'b1}} : xn_wide[RW-1:0];

  // The estimates are close enough when each lies within tol of the other.
  assign sts.neg      = s[IN_W-1];
  assign sts.zero     = (s == '0);
  assign sts.cnt_last = (cnt == CNT_W'(1));
  assign sts.conv     = (xn <= x + tol_ext) && (x <= xn + tol_ext);
  assign sts.capped   = (n >= cap);

  assign root   = out_root;
  assign status = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol      <= nsr_pkg::TOL_RESET;
      max_iter <= nsr_pkg::ITER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        nsr_pkg::CFG_TOLERANCE: tol      <= cfg_data[nsr_pkg::TOL_W-1:0];
        nsr_pkg::CFG_MAX_ITER:  max_iter <= cfg_data[IW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      s <= radicand;
    end
    if (cmd.sq_start) begin
      sq_op   <= SQ_W'(s[IN_W-1:FRAC_BITS]);
      sq_rem  <= '0;
      sq_root <= '0;
      cnt     <= CNT_W'(SQ_PAIRS);
    end
    if (cmd.sq_step) begin
      sq_op   <= sq_op << 2;
      sq_rem  <= sq_ge ? sq_diff[SQ_PAIRS:0] : sq_rem_sh[SQ_PAIRS:0];
      sq_root <= {sq_root[SQ_PAIRS-2:0], sq_ge};
      cnt     <= cnt - CNT_W'(1);
    end
    if (cmd.seed) begin
      x <= seed_x;
      n <= '0;
    end
    if (cmd.adv) begin
      x <= xn;
    end
    if (cmd.div_load) begin
      rem <= '0;
      quo <= {s, {FRAC_BITS{1'b0}}};
      cnt <= CNT_W'(QW);
    end
    if (cmd.div_step) begin
      rem <= div_ge ? div_diff[QW-1:0] : div_sh[QW-1:0];
      quo <= {quo[QW-2:0], div_ge};
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.upd) begin
      xn <= xn_calc;
      n  <= n + IW'(1);
    end
    if (cmd.out_load) begin
      out_root   <= (sts.neg || sts.zero) ? '0 : root_sat;
      out_status <= cmd.fin_status;
    end
  end

endmodule

[rtl/core/nsr_ctrl.sv]
module nsr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  nsr_pkg::sts_t sts,
  output nsr_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_START = 8'b00000010,
    S_ROOT  = 8'b00000100,
    S_SEED  = 8'b00001000,
    S_DIV   = 8'b00010000,
    S_UPD   = 8'b00100000,
    S_CHECK = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  state_t           state;
  state_t           state_next;
  nsr_pkg::status_t fin_status;
  nsr_pkg::status_t fin_status_next;
  logic             out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next      = state;
    fin_status_next = fin_status;
    cmd             = '0;
    cmd.fin_status  = fin_status;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        if (sts.neg) begin
          fin_status_next = nsr_pkg::STATUS_NEG;
          state_next      = S_FIN;
        end else if (sts.zero) begin
          fin_status_next = nsr_pkg::STATUS_OK;
          state_next      = S_FIN;
        end else begin
          cmd.sq_start = 1'b1;
          state_next   = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.sq_step = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed     = 1'b1;
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.conv) begin
          fin_status_next = nsr_pkg::STATUS_OK;
          state_next      = S_FIN;
        end else if (sts.capped) begin
          fin_status_next = nsr_pkg::STATUS_CAP;
          state_next      = S_FIN;
        end else begin
          cmd.adv      = 1'b1;
          cmd.div_load = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_FIN: begin
        // Wait here only while the output register still holds an unsent result.
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin_status <= nsr_pkg::STATUS_OK;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fin_status <= fin_status_next;
      out_valid  <= cmd.out_load || (out_valid && out_stall);
    end
  end

endmodule

[rtl/core/newton_square_root.sv]
// Square root of a signed fixed-point radicand by Newton refinement.
// Input channel: radicand (two's complement, INT_BITS.FRAC_BITS) with
// in_valid/in_stall; a request is taken when in_valid is high and in_stall low.
// Output channel: root (unsigned, 16.16 at default sizes) and status
// (0 ok, 1 negative input, 2 iteration cap reached) with out_valid/out_stall.
// Registers tolerance_lsb (index 0) and max_iterations (index 1) are written
// through cfg_write/cfg_index/cfg_data; the user must write them only while
// the block is idle, as the block itself does not enforce it.
// One request is worked at a time. Negative and zero radicands skip the root
// and Newton steps and go from S_START straight to S_FIN. The bit-serial
// divider produces one quotient bit a cycle. A new request is taken in the
// cycle after a result is loaded.
// The result sits in an output register, so the next request is taken while
// the receiver stalls; a finished result then waits until that register frees.
// Reset (synchronous) drops any request in flight, clears out_valid and loads
// tolerance_lsb = 1 and max_iterations = 32.
module newton_square_root #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nsr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] radicand,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nsr_pkg::ROOT_W-1:0]          root,
  output logic [nsr_pkg::STATUS_W-1:0]        status
);

  nsr_pkg::cmd_t    cmd;
  nsr_pkg::sts_t    sts;
  nsr_pkg::status_t status_q;

  assign status = status_q;

  nsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  nsr_dp #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .radicand  (radicand),
    .cmd       (cmd),
    .sts       (sts),
    .root      (root),
    .status    (status_q)
  );

endmodule

[rtl/core/nsr_checker.sv]
module nsr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [nsr_pkg::ROOT_W-1:0]   root,
  input logic [nsr_pkg::STATUS_W-1:0] status
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(root) && $stable(status))
    else $error("stalled result changed");

  // A taken request keeps the input side busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not busy after accepted request");

  // A new result only follows a cycle in which a request was being worked.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in flight");

  // A negative radicand always reports a zero root.
  a_neg_zero_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == nsr_pkg::STATUS_NEG) |-> (root == '0))
    else $error("negative status with nonzero root");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .root      (root),
  .status    (status)
);
